>>> rtl/core/m4inv_pkg.sv
// Shared constants, types and index helpers for the 4x4 adjugate inverse block.
package m4inv_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ELEM_W      = 32;
   localparam int IDX_W       = 4;
   localparam int NUM_ELEM    = 16;
   localparam int COF_W       = 64;
   localparam int OPND_W      = ELEM_W + 1;
   localparam int PROD_W      = 2 * OPND_W;
   localparam int ACC_W       = 100;
   localparam int NUM_W       = COF_W + FRAC_BITS + 1;
   localparam int QUO_W       = 37;
   localparam int DCNT_W      = $clog2(NUM_W + 1);
   localparam int STEP_W      = 4;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_USER_W  = 2;
   localparam int LAST_COF_STEP = 11;
   localparam int FIRST_BIG_STEP = 6;
   localparam int LAST_DET_STEP = 7;
   localparam logic [IDX_W-1:0] SOLVE_IDX = 4'd15;
   localparam logic [IDX_W-1:0] LAST_IDX  = 4'd15;

   typedef logic [1:0] lane_type;
   typedef lane_type [2:0] trio_type;

   // back end status seen by the front end
   typedef struct packed {
      logic busy;
      logic pop;
   } bk_stat_type;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_RDA     = 11'b000_0000_0010,
      ST_RDB     = 11'b000_0000_0100,
      ST_MUL     = 11'b000_0000_1000,
      ST_ACC     = 11'b000_0001_0000,
      ST_COF_RND = 11'b000_0010_0000,
      ST_DET_RND = 11'b000_0100_0000,
      ST_DIV_SET = 11'b000_1000_0000,
      ST_DIV_RUN = 11'b001_0000_0000,
      ST_DIV_FIN = 11'b010_0000_0000,
      ST_OUT     = 11'b100_0000_0000
   } bk_state_type;

   // the three lanes left once one row or column is struck out
   function automatic trio_type others(input lane_type drop);
      trio_type res;
      unique case (drop)
         2'd0:    begin res[0] = 2'd1; res[1] = 2'd2; res[2] = 2'd3; end
         2'd1:    begin res[0] = 2'd0; res[1] = 2'd2; res[2] = 2'd3; end
         2'd2:    begin res[0] = 2'd0; res[1] = 2'd1; res[2] = 2'd3; end
         default: begin res[0] = 2'd0; res[1] = 2'd1; res[2] = 2'd2; end
      endcase
      return res;
   endfunction

endpackage

>>> rtl/core/m4inv_front.sv
// Front end: takes element requests, holds the element store, queues solve tokens.
module m4inv_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [m4inv_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [m4inv_pkg::IDX_W-1:0]           rd_addr,
   output logic signed [m4inv_pkg::ELEM_W-1:0]   rd_data,
   output logic                                  tok_valid,
   input  m4inv_pkg::bk_stat_type                bk_stat
);

   logic signed [m4inv_pkg::ELEM_W-1:0] elem_ff [m4inv_pkg::NUM_ELEM];
   logic                                token_ff, token_in;
   logic                                accept;
   logic [m4inv_pkg::IDX_W-1:0]         wr_idx;

   // hold off while a solve is queued or running: the store feeds it
   assign req_tready = !token_ff && !bk_stat.busy;
   assign accept     = req_tvalid && req_tready;
   assign wr_idx     = req_tdata[m4inv_pkg::IDX_W-1:0];
   assign rd_data    = elem_ff[rd_addr];
   assign tok_valid  = token_ff;

   always_comb begin
      token_in = token_ff;
      if (bk_stat.pop) begin
         token_in = 1'b0;
      end
      if (accept && wr_idx == m4inv_pkg::SOLVE_IDX) begin
         token_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elem_ff[wr_idx] <= req_tdata[m4inv_pkg::IDX_W +: m4inv_pkg::ELEM_W];
      end
   end

endmodule

>>> rtl/core/m4inv_back.sv
// Back end: cofactor and determinant sequencer, serial divider, result register.
module m4inv_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  tok_valid,
   output m4inv_pkg::bk_stat_type                bk_stat,
   output logic [m4inv_pkg::IDX_W-1:0]           rd_addr,
   input  logic signed [m4inv_pkg::ELEM_W-1:0]   rd_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [m4inv_pkg::IDX_W-1:0]           out_index,
   output logic [m4inv_pkg::ELEM_W-1:0]          out_value,
   output logic                                  out_singular,
   output logic                                  out_saturated,
   output logic                                  out_last
);

   localparam int ACC_W  = m4inv_pkg::ACC_W;
   localparam int COF_W  = m4inv_pkg::COF_W;
   localparam int PROD_W = m4inv_pkg::PROD_W;
   localparam int OPND_W = m4inv_pkg::OPND_W;
   localparam int ELEM_W = m4inv_pkg::ELEM_W;
   localparam int NUM_W  = m4inv_pkg::NUM_W;
   localparam int QUO_W  = m4inv_pkg::QUO_W;
   localparam int FB     = m4inv_pkg::FRAC_BITS;
   localparam logic signed [ACC_W-1:0] HALF_COF = ACC_W'(1) << (2 * FB - 1);
   localparam logic signed [ACC_W-1:0] HALF_DET = ACC_W'(1) << (FB - 1);
   localparam logic [ELEM_W-1:0] POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] NEG_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   m4inv_pkg::bk_state_type state_ff, state_in;

   logic [m4inv_pkg::IDX_W-1:0]   cof_ix_ff, cof_ix_in;
   logic [m4inv_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                          det_mode_ff, det_mode_in;
   logic signed [OPND_W-1:0]      opa_ff, opb_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [COF_W-1:0]       minor_ff [3];
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [COF_W-1:0]       cof_ff [m4inv_pkg::NUM_ELEM];
   logic [m4inv_pkg::NUM_ELEM-1:0] cof_clip_ff;
   logic signed [COF_W-1:0]       det_ff;
   logic                          det_clip_ff;
   logic [m4inv_pkg::IDX_W-1:0]   emit_ff, emit_in;
   logic [NUM_W-1:0]              num_ff;
   logic [COF_W-1:0]              rem_ff;
   logic [QUO_W-1:0]              quo_ff;
   logic                          big_ff, neg_ff;
   logic [m4inv_pkg::DCNT_W-1:0]  cnt_ff;
   logic [m4inv_pkg::IDX_W-1:0]   o_idx_ff;
   logic [ELEM_W-1:0]             o_val_ff;
   logic                          o_sing_ff, o_sat_ff, o_last_ff;

   // index decode for the current cofactor step
   m4inv_pkg::trio_type rows, cols;
   m4inv_pkg::lane_type col_x, col_y, t_min, t_big;
   logic [m4inv_pkg::STEP_W-1:0] tb;
   logic                    big_step, hi_part, odd_min, term_neg, first_term;
   logic [m4inv_pkg::IDX_W-1:0] addr_a, addr_b, cof_rd, src;
   logic signed [COF_W-1:0] m_sel, c_sel;
   logic signed [OPND_W-1:0] opb_next;
   logic signed [ACC_W-1:0] wide, shifted, acc_next;
   logic signed [ACC_W-1:0] cof_sum, cof_sh, det_sum, det_sh;
   logic                    cof_fit, det_fit;
   logic signed [COF_W-1:0] cof_rnd, det_rnd;
   logic [COF_W-1:0]        cmag, dmag;
   logic [COF_W:0]          r2;
   logic                    ge;
   logic [QUO_W-1:0]        quo_next;
   logic                    clip;
   logic [ELEM_W-1:0]       qval;

   always_comb begin
      rows     = m4inv_pkg::others(cof_ix_ff[3:2]);
      cols     = m4inv_pkg::others(cof_ix_ff[1:0]);
      t_min    = step_ff[2:1];
      tb       = step_ff - m4inv_pkg::STEP_W'(m4inv_pkg::FIRST_BIG_STEP);
      t_big    = tb[2:1];
      big_step = step_ff >= m4inv_pkg::STEP_W'(m4inv_pkg::FIRST_BIG_STEP);
      hi_part  = !step_ff[0];
      odd_min  = step_ff[0];
      case (t_min)
         2'd0:    begin col_x = cols[1]; col_y = cols[2]; end
         2'd1:    begin col_x = cols[0]; col_y = cols[2]; end
         default: begin col_x = cols[0]; col_y = cols[1]; end
      endcase
      if (det_mode_ff) begin
         addr_a = {2'd0, step_ff[2:1]};
      end else if (big_step) begin
         addr_a = {rows[0], cols[t_big]};
      end else begin
         addr_a = odd_min ? {rows[1], col_y} : {rows[1], col_x};
      end
      addr_b  = odd_min ? {rows[2], col_x} : {rows[2], col_y};
      rd_addr = (state_ff == m4inv_pkg::ST_RDB) ? addr_b : addr_a;
   end

   // one read port on the cofactor registers
   assign src    = {emit_ff[1:0], emit_ff[3:2]};
   assign cof_rd = (state_ff == m4inv_pkg::ST_DIV_SET) ? src : {2'd0, step_ff[2:1]};
   assign c_sel  = cof_ff[cof_rd];
   assign m_sel  = det_mode_ff ? c_sel : minor_ff[t_big];

   always_comb begin
      if (!det_mode_ff && !big_step) begin
         opb_next = OPND_W'(rd_data);
      end else if (hi_part) begin
         opb_next = OPND_W'($signed(m_sel[COF_W-1:COF_W/2]));
      end else begin
         opb_next = {1'b0, m_sel[COF_W/2-1:0]};
      end
   end

   // accumulate one partial product of a cofactor or the determinant
   always_comb begin
      wide       = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      shifted    = hi_part ? (wide <<< (COF_W/2)) : wide;
      term_neg   = !det_mode_ff && ((t_big == 2'd1) ^ cof_ix_ff[2] ^ cof_ix_ff[0]);
      first_term = det_mode_ff ? (step_ff == '0)
                 : (step_ff == m4inv_pkg::STEP_W'(m4inv_pkg::FIRST_BIG_STEP));
      acc_next   = (first_term ? '0 : acc_ff) + (term_neg ? -shifted : shifted);
   end

   // round half up, then saturate to 64 bits
   always_comb begin
      cof_sum = acc_ff + HALF_COF;
      cof_sh  = cof_sum >>> (2 * FB);
      cof_fit = (cof_sh[ACC_W-1:COF_W-1] == '0) || (cof_sh[ACC_W-1:COF_W-1] == '1);
      cof_rnd = cof_fit ? cof_sh[COF_W-1:0]
              : (cof_sh[ACC_W-1] ? {1'b1, {(COF_W-1){1'b0}}} : {1'b0, {(COF_W-1){1'b1}}});
      det_sum = acc_ff + HALF_DET;
      det_sh  = det_sum >>> FB;
      det_fit = (det_sh[ACC_W-1:COF_W-1] == '0) || (det_sh[ACC_W-1:COF_W-1] == '1);
      det_rnd = det_fit ? det_sh[COF_W-1:0]
              : (det_sh[ACC_W-1] ? {1'b1, {(COF_W-1){1'b0}}} : {1'b0, {(COF_W-1){1'b1}}});
   end

   // restoring divider, one numerator bit a cycle
   always_comb begin
      cmag     = c_sel[COF_W-1] ? (COF_W'(0) - c_sel) : c_sel;
      dmag     = det_ff[COF_W-1] ? (COF_W'(0) - det_ff) : det_ff;
      r2       = {rem_ff, num_ff[NUM_W-1]};
      ge       = r2 >= {1'b0, dmag};
      quo_next = big_ff ? quo_ff : {quo_ff[QUO_W-2:0], ge};
      if (neg_ff) begin
         clip = big_ff || (quo_ff > QUO_W'(NEG_MIN));
         qval = clip ? NEG_MIN : (ELEM_W'(0) - quo_ff[ELEM_W-1:0]);
      end else begin
         clip = big_ff || (quo_ff > QUO_W'(POS_MAX));
         qval = clip ? POS_MAX : quo_ff[ELEM_W-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      cof_ix_in   = cof_ix_ff;
      step_in     = step_ff;
      det_mode_in = det_mode_ff;
      emit_in     = emit_ff;
      unique case (state_ff)
         m4inv_pkg::ST_IDLE: begin
            if (tok_valid) begin
               cof_ix_in   = '0;
               step_in     = '0;
               det_mode_in = 1'b0;
               state_in    = m4inv_pkg::ST_RDA;
            end
         end
         m4inv_pkg::ST_RDA: state_in = m4inv_pkg::ST_RDB;
         m4inv_pkg::ST_RDB: state_in = m4inv_pkg::ST_MUL;
         m4inv_pkg::ST_MUL: state_in = m4inv_pkg::ST_ACC;
         m4inv_pkg::ST_ACC: begin
            step_in  = step_ff + 1'b1;
            state_in = m4inv_pkg::ST_RDA;
            if (det_mode_ff && step_ff == m4inv_pkg::STEP_W'(m4inv_pkg::LAST_DET_STEP)) begin
               state_in = m4inv_pkg::ST_DET_RND;
            end else if (!det_mode_ff
                         && step_ff == m4inv_pkg::STEP_W'(m4inv_pkg::LAST_COF_STEP)) begin
               state_in = m4inv_pkg::ST_COF_RND;
            end
         end
         m4inv_pkg::ST_COF_RND: begin
            step_in   = '0;
            cof_ix_in = cof_ix_ff + 1'b1;
            state_in  = m4inv_pkg::ST_RDA;
            if (cof_ix_ff == m4inv_pkg::LAST_IDX) begin
               det_mode_in = 1'b1;
            end
         end
         m4inv_pkg::ST_DET_RND: begin
            emit_in  = '0;
            state_in = m4inv_pkg::ST_DIV_SET;
         end
         m4inv_pkg::ST_DIV_SET: begin
            state_in = (det_ff == '0) ? m4inv_pkg::ST_OUT : m4inv_pkg::ST_DIV_RUN;
         end
         m4inv_pkg::ST_DIV_RUN: begin
            if (cnt_ff == m4inv_pkg::DCNT_W'(NUM_W - 1)) begin
               state_in = m4inv_pkg::ST_DIV_FIN;
            end
         end
         m4inv_pkg::ST_DIV_FIN: state_in = m4inv_pkg::ST_OUT;
         m4inv_pkg::ST_OUT: begin
            if (rsp_tready) begin
               emit_in  = emit_ff + 1'b1;
               state_in = (emit_ff == m4inv_pkg::LAST_IDX) ? m4inv_pkg::ST_IDLE
                        : m4inv_pkg::ST_DIV_SET;
            end
         end
         default: state_in = m4inv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= m4inv_pkg::ST_IDLE;
         cof_ix_ff   <= '0;
         step_ff     <= '0;
         det_mode_ff <= 1'b0;
         emit_ff     <= '0;
         det_ff      <= '0;
         det_clip_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cof_ix_ff   <= cof_ix_in;
         step_ff     <= step_in;
         det_mode_ff <= det_mode_in;
         emit_ff     <= emit_in;
         if (state_ff == m4inv_pkg::ST_DET_RND) begin
            det_ff      <= det_rnd;
            det_clip_ff <= !det_fit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == m4inv_pkg::ST_RDA) begin
         opa_ff <= OPND_W'(rd_data);
      end
      if (state_ff == m4inv_pkg::ST_RDB) begin
         opb_ff <= opb_next;
      end
      if (state_ff == m4inv_pkg::ST_MUL) begin
         prod_ff <= opa_ff * opb_ff;
      end
      if (state_ff == m4inv_pkg::ST_ACC) begin
         if (!det_mode_ff && !big_step) begin
            minor_ff[t_min] <= odd_min ? (minor_ff[t_min] - prod_ff[COF_W-1:0])
                                       : prod_ff[COF_W-1:0];
         end else begin
            acc_ff <= acc_next;
         end
      end
      if (state_ff == m4inv_pkg::ST_COF_RND) begin
         cof_ff[cof_ix_ff]      <= cof_rnd;
         cof_clip_ff[cof_ix_ff] <= !cof_fit;
      end
      if (state_ff == m4inv_pkg::ST_DIV_SET) begin
         num_ff    <= {1'b0, cmag, FB'(0)} + NUM_W'(dmag >> 1);
         rem_ff    <= '0;
         quo_ff    <= '0;
         big_ff    <= 1'b0;
         cnt_ff    <= '0;
         neg_ff    <= c_sel[COF_W-1] ^ det_ff[COF_W-1];
         o_idx_ff  <= emit_ff;
         o_last_ff <= emit_ff == m4inv_pkg::LAST_IDX;
         o_val_ff  <= '0;
         o_sing_ff <= det_ff == '0;
         o_sat_ff  <= 1'b0;
      end
      if (state_ff == m4inv_pkg::ST_DIV_RUN) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= ge ? COF_W'(r2 - {1'b0, dmag}) : r2[COF_W-1:0];
         quo_ff <= quo_next;
         big_ff <= big_ff | quo_next[QUO_W-1];
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (state_ff == m4inv_pkg::ST_DIV_FIN) begin
         o_val_ff <= qval;
         o_sat_ff <= clip || det_clip_ff || cof_clip_ff[src];
      end
   end

   assign bk_stat.busy = state_ff != m4inv_pkg::ST_IDLE;
   assign bk_stat.pop  = (state_ff == m4inv_pkg::ST_IDLE) && tok_valid;
   assign rsp_tvalid    = state_ff == m4inv_pkg::ST_OUT;
   assign out_index     = o_idx_ff;
   assign out_value     = o_val_ff;
   assign out_singular  = o_sing_ff;
   assign out_saturated = o_sat_ff;
   assign out_last      = o_last_ff;

endmodule

>>> rtl/core/matrix4_inverse_adjugate.sv
// Top level of the 4x4 matrix inverse by adjugate, Q.F fixed point.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata: elem_index[3:0], elem_value[35:4]
//  rsp      out  rsp_tvalid/rsp_tready  tdata: out_index[3:0], out_value[35:4]
//                                       tuser: singular[0], saturated[1]; tlast
//
// Element 15 starts a solve: sixteen cofactors and the determinant are
// formed through one shared 33x33 multiplier, then per result a bit-serial
// division and an output state (no division when the determinant is zero).
// Requests are held off from the accept of element 15 until the last result
// is taken. Reset is synchronous and clears control state and the
// determinant register only.
module matrix4_inverse_adjugate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // elem_index[3:0], elem_value[35:4], zero fill [39:36]
   input  logic [m4inv_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_index[3:0], out_value[35:4], zero fill [39:36]
   output logic [m4inv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // singular[0], saturated[1]
   output logic [m4inv_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                                rsp_tlast
);

   logic [m4inv_pkg::IDX_W-1:0]          rd_addr;
   logic signed [m4inv_pkg::ELEM_W-1:0]  rd_data;
   logic                                 tok_valid;
   m4inv_pkg::bk_stat_type               bk_stat;
   logic [m4inv_pkg::IDX_W-1:0]          out_index;
   logic [m4inv_pkg::ELEM_W-1:0]         out_value;
   logic                                 out_singular, out_saturated;

   // front: element store and a one-entry solve token queue
   m4inv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .tok_valid  (tok_valid),
      .bk_stat    (bk_stat)
   );

   // back: cofactors, determinant, division and the result register
   m4inv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .tok_valid     (tok_valid),
      .bk_stat       (bk_stat),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .out_index     (out_index),
      .out_value     (out_value),
      .out_singular  (out_singular),
      .out_saturated (out_saturated),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = {{(m4inv_pkg::RSP_DATA_W - m4inv_pkg::ELEM_W - m4inv_pkg::IDX_W){1'b0}},
                       out_value, out_index};
   assign rsp_tuser = {out_saturated, out_singular};

endmodule
